// ----- hw/rtl/htmg_pkg.sv -----
// ============================================================================
// htmg_pkg: shared constants and elaboration-time functions
// Formats, stage counts and the exponent table generator for the HDR tone
// mapper with gamma encoding.
// ============================================================================
package htmg_pkg;

  // Channel count and field widths
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned IN_CH_W  = 24;
  localparam int unsigned OUT_CH_W = 16;
  localparam int unsigned IN_W     = NUM_CH * IN_CH_W;
  localparam int unsigned OUT_W    = NUM_CH * OUT_CH_W;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [23:0] SCALED_MAX  = 24'hFFFFFF;
  localparam logic [23:0] F_CLAMP_LIM = 24'd327680;  // (m - 1) * 0.2 reaches 1.0
  localparam logic [19:0] DIV5_RECIP  = 20'd838861;  // ceil(2^22 / 5)
  localparam int unsigned DIV5_SHIFT  = 22;
  localparam logic [37:0] IP_ZERO_LIM = 38'd18;       // result rounds to zero

  // Register reset values
  localparam logic [23:0] INV_SENS_RST  = 24'd65536;
  localparam logic [15:0] INV_GAMMA_RST = 16'd1862;

  // Pipeline depths
  localparam int unsigned FRONT_LAT  = 5;
  localparam int unsigned DIV_STAGES = 17;
  localparam int unsigned SQ_STAGES  = 16;
  localparam int unsigned ENC_LAT    = SQ_STAGES + 7;
  localparam int unsigned PIPE_LAT   = FRONT_LAT + DIV_STAGES + ENC_LAT;

  localparam int unsigned POW_TABLE_BITS_DEF = 8;

  // Register index decode
  typedef enum logic [0:0] {
    REG_INV_SENS  = 1'b0,
    REG_INV_GAMMA = 1'b1
  } reg_idx_e;

  // Floored integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bt;
    a   = a_in;
    res = 64'd0;
    bt  = 64'h4000_0000_0000_0000;
    while (bt > a) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (a >= res + bt) begin
        a   = a - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q0.32
  function automatic logic [63:0] halving_root(input int unsigned k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int unsigned i = 1; i < k; i++) c = isqrt64(c << 32);
    return c;
  endfunction

  // 2^(-j / 2^bits) in Q0.32, up to 2^32
  function automatic logic [63:0] exp_frac(input int unsigned j, input int unsigned bits);
    logic [63:0] t;
    t = 64'h1_0000_0000;
    for (int unsigned b = 0; b < bits; b++) begin
      if (((j >> b) & 1) != 0) t = (t * halving_root(bits - b)) >> 32;
    end
    return t;
  endfunction

endpackage

// ----- hw/rtl/htmg_front.sv -----
// ============================================================================
// htmg_front: sensitivity scaling, channel maximum and white blend factor
// Five register stages shared by all three channels.
// ============================================================================
module htmg_front (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [htmg_pkg::NUM_CH-1:0][23:0]      pix_i,
  input  logic [23:0]                            inv_sens_i,
  output logic [htmg_pkg::NUM_CH-1:0][23:0]      s_o,
  output logic [23:0]                            m_o,
  output logic [16:0]                            f_o
);
  import htmg_pkg::*;

  logic [NUM_CH-1:0][47:0] prod_q;
  logic [NUM_CH-1:0][23:0] s2_q, s3_q, s4_q, s5_q;
  logic [23:0]             m_d, m3_q, m4_q, m5_q;
  logic [23:0]             x_d;
  logic                    big_q;
  logic [38:0]             fprod_q;
  logic [16:0]             f5_q;

  // Largest channel, floored at one
  always_comb begin
    m_d = 24'(ONE_Q16);
    for (int c = 0; c < NUM_CH; c++) begin
      if (s2_q[c] > m_d) m_d = s2_q[c];
    end
  end

  assign x_d = m3_q - 24'(ONE_Q16);

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_q[c] <= 48'(pix_i[c]) * 48'(inv_sens_i);
        s2_q[c]   <= (|prod_q[c][47:40]) ? SCALED_MAX : prod_q[c][39:16];
      end
      s3_q    <= s2_q;
      m3_q    <= m_d;
      s4_q    <= s3_q;
      m4_q    <= m3_q;
      big_q   <= (x_d >= F_CLAMP_LIM);
      fprod_q <= 39'(x_d[18:0]) * 39'(DIV5_RECIP);
      s5_q    <= s4_q;
      m5_q    <= m4_q;
      f5_q    <= big_q ? ONE_Q16 : 17'(fprod_q >> DIV5_SHIFT);
    end
  end

  assign s_o = s5_q;
  assign m_o = m5_q;
  assign f_o = f5_q;

endmodule

// ----- hw/rtl/htmg_div.sv -----
// ============================================================================
// htmg_div: pipelined restoring divider for one channel
// Produces n = (s << 16) / m, one quotient bit per stage.
// ============================================================================
module htmg_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [23:0]                       s_i,
  input  logic [23:0]                       m_i,
  output logic [htmg_pkg::DIV_STAGES-1:0]   q_o
);
  import htmg_pkg::*;

  logic [23:0]           r_d [DIV_STAGES];
  logic [23:0]           r_q [DIV_STAGES];
  logic [23:0]           m_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_q [DIV_STAGES];

  // One compare and subtract per stage
  always_comb begin
    logic [24:0] rr;
    logic        ge;
    rr     = {1'b0, s_i};
    ge     = (rr >= {1'b0, m_i});
    r_d[0] = ge ? 24'(rr - {1'b0, m_i}) : s_i;
    q_d[0] = {{(DIV_STAGES-1){1'b0}}, ge};
    for (int i = 1; i < DIV_STAGES; i++) begin
      rr     = {r_q[i-1], 1'b0};
      ge     = (rr >= {1'b0, m_q[i-1]});
      r_d[i] = ge ? 24'(rr - {1'b0, m_q[i-1]}) : rr[23:0];
      q_d[i] = {q_q[i-1][DIV_STAGES-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m_i;
      for (int i = 1; i < DIV_STAGES; i++) m_q[i] <= m_q[i-1];
      for (int i = 0; i < DIV_STAGES; i++) begin
        r_q[i] <= r_d[i];
        q_q[i] <= q_d[i];
      end
    end
  end

  assign q_o = q_q[DIV_STAGES-1];

endmodule

// ----- hw/rtl/htmg_enc.sv -----
// ============================================================================
// htmg_enc: white blend and gamma encoding for one channel
// Blend, log2 by repeated squaring, exponent scaling, table lookup of the
// fractional power of two and final rounding with saturation.
// ============================================================================
module htmg_enc #(
  parameter int unsigned POW_TABLE_BITS = htmg_pkg::POW_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] n_i,
  input  logic [16:0] f_i,
  input  logic [15:0] inv_gamma_i,
  output logic [15:0] y_o
);
  import htmg_pkg::*;

  localparam int unsigned TBL = 1 << POW_TABLE_BITS;

  // Fractional power table
  logic [32:0] rom [TBL];
  for (genvar g = 0; g < TBL; g++) begin : g_rom
    assign rom[g] = 33'(exp_frac(g, POW_TABLE_BITS));
  end

  // One squaring step: returns the fraction bit and the renormalized value
  function automatic logic [31:0] sq_step(input logic [30:0] x);
    logic [61:0] sq;
    sq = 62'(x) * 62'(x);
    return sq[61] ? {1'b1, sq[61:31]} : {1'b0, sq[60:30]};
  endfunction

  logic [33:0] bp_q;
  logic [16:0] f1_q;
  logic [33:0] bsum;
  logic [16:0] v_q;

  logic [3:0]  e_d;
  logic [3:0]  e0_q;
  logic [30:0] x0_q;
  logic        z0_q, o0_q;

  logic [31:0] st_d [SQ_STAGES];
  logic [30:0] x_q  [SQ_STAGES];
  logic [15:0] fr_q [SQ_STAGES];
  logic [3:0]  e_q  [SQ_STAGES];
  logic        z_q  [SQ_STAGES];
  logic        o_q  [SQ_STAGES];

  logic [20:0] d_d;
  logic [36:0] y_q;
  logic        zy_q, oy_q;

  logic [37:0] ysum, yqv, ipw;
  logic [POW_TABLE_BITS-1:0] j_q;
  logic [4:0]  ipj_q, ipt_q;
  logic        kj_q, zj_q, oj_q, kt_q, zt_q, ot_q;
  logic [32:0] t_q;

  logic [33:0] rnd, rsh;
  logic [15:0] r_d;
  logic [15:0] out_q;

  assign bsum = bp_q + {1'b0, f1_q, 16'b0};

  // Leading one of the blended value
  always_comb begin
    e_d = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (v_q[b]) e_d = 4'(b);
    end
  end

  // Squaring chain steps
  always_comb begin
    st_d[0] = sq_step(x0_q);
    for (int i = 1; i < SQ_STAGES; i++) st_d[i] = sq_step(x_q[i-1]);
  end

  assign d_d = {5'(5'd16 - {1'b0, e_q[SQ_STAGES-1]}), 16'b0} - {5'b0, fr_q[SQ_STAGES-1]};

  // Round the scaled exponent at the table resolution
  assign ysum = {1'b0, y_q} + (38'd1 << (27 - POW_TABLE_BITS));
  assign yqv  = ysum >> (28 - POW_TABLE_BITS);
  assign ipw  = yqv >> POW_TABLE_BITS;

  // Round to Q0.16 and saturate
  assign rnd = {1'b0, t_q} + (34'd1 << (6'd15 + {1'b0, ipt_q}));
  assign rsh = rnd >> (6'd16 + {1'b0, ipt_q});
  assign r_d = (|rsh[33:16]) ? 16'hFFFF : rsh[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // blend toward white
      bp_q <= 34'(n_i) * 34'(17'(ONE_Q16 - f_i));
      f1_q <= f_i;
      v_q  <= bsum[32:16];
      // normalize
      e0_q <= e_d;
      x0_q <= 31'(v_q[15:0]) << (5'd30 - {1'b0, e_d});
      z0_q <= (v_q == 17'd0);
      o0_q <= v_q[16];
      // log2 fraction bits
      x_q[0]  <= st_d[0][30:0];
      fr_q[0] <= {15'b0, st_d[0][31]};
      e_q[0]  <= e0_q;
      z_q[0]  <= z0_q;
      o_q[0]  <= o0_q;
      for (int i = 1; i < SQ_STAGES; i++) begin
        x_q[i]  <= st_d[i][30:0];
        fr_q[i] <= {fr_q[i-1][14:0], st_d[i][31]};
        e_q[i]  <= e_q[i-1];
        z_q[i]  <= z_q[i-1];
        o_q[i]  <= o_q[i-1];
      end
      // scale by the exponent
      y_q  <= 37'(d_d) * 37'(inv_gamma_i);
      zy_q <= z_q[SQ_STAGES-1];
      oy_q <= o_q[SQ_STAGES-1];
      // split into integer and table index
      j_q   <= yqv[POW_TABLE_BITS-1:0];
      ipj_q <= ipw[4:0];
      kj_q  <= (ipw >= IP_ZERO_LIM);
      zj_q  <= zy_q;
      oj_q  <= oy_q;
      // table read
      t_q   <= rom[j_q];
      ipt_q <= ipj_q;
      kt_q  <= kj_q;
      zt_q  <= zj_q;
      ot_q  <= oj_q;
      // final select
      if (ot_q) begin
        out_q <= 16'hFFFF;
      end else if (zt_q) begin
        out_q <= (inv_gamma_i == 16'd0) ? 16'hFFFF : 16'd0;
      end else if (kt_q) begin
        out_q <= 16'd0;
      end else begin
        out_q <= r_d;
      end
    end
  end

  assign y_o = out_q;

endmodule

// ----- hw/rtl/hdr_tone_map_gamma.sv -----
// ============================================================================
// hdr_tone_map_gamma: HDR tone mapper with gamma encoding
// Scales, normalizes, blends toward white and gamma encodes one RGB pixel
// per clock while the output side does not stall the pipeline.
// ============================================================================
// Takes one pixel beat per clock while the skid stage is empty and returns one
// result beat per pixel, in order. Most of the depth comes from the 17-stage
// restoring divider that normalizes each channel by the brightest one and the
// 16-stage squaring chain that forms log2; both advance one step per clock
// while no stall holds the pipeline, so throughput is then one pixel per cycle.
// An output register backed by a one-beat skid stage keeps the input side
// taking a beat while a result waits. Registers: inv_sensitivity at 0x0
// (Q8.16), inv_gamma at 0x4 (Q4.12); write them only while the block is idle.
module hdr_tone_map_gamma #(
  parameter int unsigned POW_TABLE_BITS = htmg_pkg::POW_TABLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // {blue_in, green_in, red_in}, red_in in bits 23:0
  input  logic [htmg_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // {blue_out, green_out, red_out}, red_out in bits 15:0
  output logic [htmg_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import htmg_pkg::*;

  logic [23:0] isens_q;
  logic [15:0] ig_q;
  logic        cfg_we;

  logic                    adv, in_fire, p_fire, out_free;
  logic [PIPE_LAT-1:0]     vld_q;
  logic [NUM_CH-1:0][23:0] pix, s_w;
  logic [23:0]             m_w;
  logic [16:0]             f_w;
  logic [16:0]             f_dly_q [DIV_STAGES];
  logic [NUM_CH-1:0][15:0] y_w;

  logic             out_valid_q, skid_valid_q;
  logic [OUT_W-1:0] out_data_q, skid_data_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isens_q <= INV_SENS_RST;
      ig_q    <= INV_GAMMA_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_INV_SENS:  isens_q <= pwdata[23:0];
        REG_INV_GAMMA: ig_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_INV_SENS:  prdata = {8'b0, isens_q};
      REG_INV_GAMMA: prdata = {16'b0, ig_q};
      default:       prdata = 32'b0;
    endcase
  end

  // Pipeline advance: hold everything while the skid stage is occupied
  assign adv             = !skid_valid_q;
  assign s_axis_tready_o = adv;
  assign in_fire         = s_axis_tvalid_i & adv;
  assign p_fire          = adv & vld_q[PIPE_LAT-1];
  assign pix             = s_axis_tdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_fire};
    end
  end

  htmg_front u_front (
    .clk_i      (clk_i),
    .en_i       (adv),
    .pix_i      (pix),
    .inv_sens_i (isens_q),
    .s_o        (s_w),
    .m_o        (m_w),
    .f_o        (f_w)
  );

  // Delay the blend factor alongside the divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_dly_q[0] <= f_w;
      for (int i = 1; i < DIV_STAGES; i++) f_dly_q[i] <= f_dly_q[i-1];
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    logic [DIV_STAGES-1:0] n_w;

    htmg_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .s_i   (s_w[c]),
      .m_i   (m_w),
      .q_o   (n_w)
    );

    htmg_enc #(
      .POW_TABLE_BITS (POW_TABLE_BITS)
    ) u_enc (
      .clk_i       (clk_i),
      .en_i        (adv),
      .n_i         (n_w),
      .f_i         (f_dly_q[DIV_STAGES-1]),
      .inv_gamma_i (ig_q),
      .y_o         (y_w[c])
    );
  end

  // Output register with skid stage
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= p_fire;
      end
    end else if (p_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (p_fire) begin
        out_data_q <= y_w;
      end
    end else if (p_fire) begin
      skid_data_q <= y_w;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while the output register is empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_fire |=> (out_valid_q || skid_valid_q))
    else $error("finished beat left the pipeline without being captured");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready_i) |=> !skid_valid_q)
    else $error("skid stage did not drain when the output was taken");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule
